FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the capture log.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Property whose consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/tccl_pkg.sv
// Package for the timestamped code capture log: sizes, codes and types.
// No dependencies; imported by timestamped_code_capture_log.
`default_nettype none

package tccl_pkg;

    // Log geometry
    localparam int LOG_DEPTH = 16;
    localparam int IDX_W     = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1);

    // Clock limits
    localparam int MILLIS_W = 10;
    localparam int SEC_W    = 16;
    localparam logic [MILLIS_W-1:0] MILLIS_LAST = MILLIS_W'(999);
    localparam logic [SEC_W-1:0]    SECONDS_MAX = 16'hFFFF;

    // Stream widths
    localparam int CODE_W     = 8;
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 3;
    localparam int ENTRY_W    = CODE_W + SEC_W + MILLIS_W;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_CAPTURE = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_READ    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STS_DONE  = 2'd0,
        STS_ENTRY = 2'd1,
        STS_EMPTY = 2'd2,
        STS_FULL  = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ_WAIT
    } state_t;

    // One log entry, code in the low bits
    typedef struct packed {
        logic [MILLIS_W-1:0] millis;
        logic [SEC_W-1:0]    seconds;
        logic [CODE_W-1:0]   code;
    } entry_t;

endpackage

`default_nettype wire

FILE: hdl/timestamped_code_capture_log.sv
// Top level of the timestamped code capture log: clock, log memory, read back.
// Depends on tccl_pkg and assert_macros.svh.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tdata code_byte, s_tuser opcode,is_data
// m_*      out  m_tvalid/m_tready  m_tdata code,seconds,millis, m_tuser status
//
// Tick, capture and clear words, and a read of an empty log, have their result
// registered straight in the output register; a read of a filled log goes first
// through the registered read port of the log memory, then the output register.
// One word is in work at a time; the output register lets the next word be
// taken in the cycle its predecessor's result is taken.
// rst_n clears the clock, fill count, read pointer and control; the log
// memory itself is not cleared and is only read below the fill level.
`default_nettype none

module timestamped_code_capture_log
(
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire  [tccl_pkg::IN_DATA_W-1:0] s_tdata,   // [7:0] code_byte
    input  wire  [tccl_pkg::IN_USER_W-1:0] s_tuser,   // [1:0] opcode, [2] is_data
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [tccl_pkg::OUT_DATA_W-1:0] m_tdata,  // [7:0] code, [23:8] seconds,
                                                       // [33:24] millis, rest zero
    output logic [tccl_pkg::OUT_USER_W-1:0] m_tuser   // [1:0] status
);
    import tccl_pkg::*;

    // Log memory
    entry_t log_mem [LOG_DEPTH];
    entry_t mem_rd_q;
    logic   mem_wr_en;
    logic   mem_rd_en;
    entry_t mem_wr_data;

    // Control and clock state
    state_t              state_reg, state_next;
    logic [MILLIS_W-1:0] millis_reg, millis_next;
    logic [SEC_W-1:0]    seconds_reg, seconds_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [IDX_W-1:0]    rptr_reg, rptr_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    entry_t              out_entry_reg, out_entry_next;

    opcode_t          op;
    logic             is_data;
    logic             s_acc;
    logic             log_full;
    logic [CNT_W-1:0] rptr_inc;

    assign op       = opcode_t'(s_tuser[1:0]);
    assign is_data  = s_tuser[2];
    assign s_acc    = s_tvalid && s_tready;
    assign log_full = (fill_reg == CNT_W'(LOG_DEPTH));
    assign rptr_inc = CNT_W'(rptr_reg) + CNT_W'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc && op == OP_READ && fill_reg != '0)
                begin
                    state_next = ST_READ_WAIT;
                end
            end
            ST_READ_WAIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:      s_tready = !out_valid_reg || m_tready;
            ST_READ_WAIT: s_tready = 1'b0;
            default:      s_tready = 1'b0;
        endcase
    end

    // Word processing: clock, fill count, read pointer, result
    always_comb
    begin
        millis_next     = millis_reg;
        seconds_next    = seconds_reg;
        fill_next       = fill_reg;
        rptr_next       = rptr_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        mem_wr_en       = 1'b0;
        mem_rd_en       = 1'b0;
        mem_wr_data     = '0;

        if (state_reg == ST_READ_WAIT)
        begin
            // read data arrived from the memory
            out_valid_next  = 1'b1;
            out_status_next = STS_ENTRY;
            out_entry_next  = mem_rd_q;
        end
        else if (s_acc)
        begin
            out_valid_next  = 1'b1;
            out_status_next = STS_DONE;
            out_entry_next  = '0;
            case (op)
                OP_TICK:
                begin
                    if (millis_reg == MILLIS_LAST)
                    begin
                        millis_next = '0;
                        if (seconds_reg != SECONDS_MAX)
                        begin
                            seconds_next = seconds_reg + SEC_W'(1);
                        end
                    end
                    else
                    begin
                        millis_next = millis_reg + MILLIS_W'(1);
                    end
                end
                OP_CAPTURE:
                begin
                    if (is_data)
                    begin
                        if (log_full)
                        begin
                            out_status_next = STS_FULL;
                        end
                        else
                        begin
                            mem_wr_en        = 1'b1;
                            mem_wr_data.code = s_tdata[CODE_W-1:0];
                            // first entry is stamped zero and restarts the clock
                            if (fill_reg == '0)
                            begin
                                millis_next  = '0;
                                seconds_next = '0;
                            end
                            else
                            begin
                                mem_wr_data.seconds = seconds_reg;
                                mem_wr_data.millis  = millis_reg;
                            end
                            fill_next = fill_reg + CNT_W'(1);
                        end
                    end
                end
                OP_CLEAR:
                begin
                    fill_next = '0;
                    rptr_next = '0;
                end
                OP_READ:
                begin
                    if (fill_reg == '0)
                    begin
                        out_status_next = STS_EMPTY;
                    end
                    else
                    begin
                        // result waits in ST_READ_WAIT for the registered memory read
                        out_valid_next = 1'b0;
                        mem_rd_en      = 1'b1;
                        if (rptr_inc >= fill_reg)
                        begin
                            rptr_next = '0;
                        end
                        else
                        begin
                            rptr_next = rptr_inc[IDX_W-1:0];
                        end
                    end
                end
                default:
                begin
                    out_status_next = STS_DONE;
                end
            endcase
        end
    end

    // Log memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            log_mem[fill_reg[IDX_W-1:0]] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            mem_rd_q <= log_mem[rptr_reg];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            millis_reg    <= '0;
            seconds_reg   <= '0;
            fill_reg      <= '0;
            rptr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            millis_reg    <= millis_next;
            seconds_reg   <= seconds_next;
            fill_reg      <= fill_next;
            rptr_reg      <= rptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_entry_reg  <= out_entry_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(OUT_DATA_W - ENTRY_W){1'b0}}, out_entry_reg};

    // Assertions
`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_reg <= CNT_W'(LOG_DEPTH))
    `ASSERT_ALWAYS(a_rptr_below_fill, clk, rst_n,
        (fill_reg == '0) || (CNT_W'(rptr_reg) < fill_reg))
    `ASSERT_ALWAYS(a_millis_range, clk, rst_n, millis_reg <= MILLIS_LAST)
    `ASSERT_ALWAYS(a_wait_out_free, clk, rst_n, (state_reg != ST_READ_WAIT) || !out_valid_reg)
    `ASSERT_NEXT(a_read_result, clk, rst_n, state_reg == ST_READ_WAIT,
        out_valid_reg && out_status_reg == STS_ENTRY)

endmodule

`default_nettype wire
